// ===== rtl/dspe_pkg.sv =====
// Shared types, codes and constants for the dense shortest-path engine.
// No dependencies; every other file of the block but dspe_ram imports this package.
`timescale 1ns / 1ps

package dspe_pkg;

    localparam int DSPE_VERTICES    = 16;
    localparam int DSPE_WEIGHT_BITS = 20;
    localparam int DSPE_VTX_BITS    = 4;

    localparam logic [DSPE_WEIGHT_BITS-1:0] DSPE_NO_EDGE_RESET = 20'd999999;

    typedef logic [DSPE_WEIGHT_BITS-1:0] weight_t;
    typedef logic [DSPE_VTX_BITS-1:0]    vtx_t;

    typedef enum logic
    {
        FUNC_WRITE = 1'b0,
        FUNC_RUN   = 1'b1
    } func_t;

    typedef enum logic [1:0]
    {
        ALU_SCAN,
        ALU_RELAX,
        ALU_REACH
    } alu_op_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_REDUCE,
        ST_INIT,
        ST_SCAN,
        ST_RELAX,
        ST_OUT_READ,
        ST_OUT_LOAD
    } seq_state_t;

    // One word of per-vertex run state
    typedef struct packed
    {
        logic    done;
        vtx_t    prev;
        weight_t path_len;
    } vstate_t;

    // Run request from the input side to the sequencer
    typedef struct packed
    {
        logic start;
        vtx_t source;
    } run_req_t;

    // Result request from the sequencer to the output register
    typedef struct packed
    {
        logic    load;
        vtx_t    vertex;
        weight_t path_length;
        logic    reachable;
        vtx_t    predecessor;
        logic    last;
    } out_req_t;

endpackage

// ===== rtl/dspe_ram.sv =====
// Simple dual-port RAM: one write port, one read port with registered data.
// No dependencies; used for the weight matrix and the per-vertex state.
`timescale 1ns / 1ps

module dspe_ram
#(
    parameter int ADDR_BITS = 8,
    parameter int DATA_BITS = 20
)
(
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [DATA_BITS-1:0] wdata,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [DATA_BITS-1:0] rdata
);

    logic [DATA_BITS-1:0] mem [0:(1 << ADDR_BITS)-1];
    logic [DATA_BITS-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/dspe_alu.sv =====
// Shared add/saturate/compare unit of the shortest-path engine.
// Depends on dspe_pkg for the weight type and the operation codes.
`timescale 1ns / 1ps

module dspe_alu
(
    input  dspe_pkg::alu_op_t op,
    input  dspe_pkg::weight_t cur,
    input  dspe_pkg::weight_t base,
    input  dspe_pkg::weight_t weight,
    input  dspe_pkg::weight_t no_edge,
    output dspe_pkg::weight_t sum,
    output logic              lt
);

    import dspe_pkg::*;

    logic [DSPE_WEIGHT_BITS:0] raw;

    // Path sum, clamped at the no-edge ceiling
    assign raw = {1'b0, base} + {1'b0, weight};
    assign sum = (raw > {1'b0, no_edge}) ? no_edge : raw[DSPE_WEIGHT_BITS-1:0];

    always_comb
    begin
        case (op)
            ALU_SCAN:  lt = cur < base;
            ALU_RELAX: lt = sum < cur;
            ALU_REACH: lt = cur < no_edge;
            default:   lt = 1'b0;
        endcase
    end

endmodule

// ===== rtl/dspe_seq.sv =====
// Run sequencer: source fold, init, min-scan and relax sweeps, then the result sweep.
// Depends on dspe_pkg, dspe_ram (vertex state) and dspe_alu.
`timescale 1ns / 1ps

module dspe_seq
#(
    parameter int NUM_VERTICES = dspe_pkg::DSPE_VERTICES
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  dspe_pkg::weight_t                    no_edge,
    input  dspe_pkg::run_req_t                   run,
    input  logic                                 out_free,
    output logic                                 idle,
    output dspe_pkg::out_req_t                   out_req,
    output logic [2*$clog2(NUM_VERTICES)-1:0]    maddr,
    input  dspe_pkg::weight_t                    mrdata
);

    import dspe_pkg::*;

    localparam int VW = $clog2(NUM_VERTICES);
    localparam int CW = VW + 1;
    localparam logic [CW-1:0] CNT_LAST = CW'(NUM_VERTICES - 1);
    localparam logic [CW-1:0] CNT_END  = CW'(NUM_VERTICES);
    localparam logic [VW-1:0] ITER_LAST = VW'(NUM_VERTICES - 1);
    localparam logic [6:0]    N_EXT    = 7'(NUM_VERTICES);

    seq_state_t    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [VW-1:0] iter_reg, iter_next;
    logic          found_reg, found_next;
    logic          rdv_reg, rdv_next;
    logic [VW-1:0] idx_reg, idx_next;
    weight_t       least_reg, least_next;
    logic [VW-1:0] pick_reg, pick_next;
    vtx_t          src_reg, src_next;

    logic [VW-1:0] cnt_idx;
    logic [VW-1:0] src_idx;
    logic [7:0]    src_wide;
    logic [6:0]    src_ext;
    logic [7:0]    pick_wide;
    logic [7:0]    cnt_wide;
    vtx_t          pick_vtx;
    vtx_t          cnt_vtx;
    logic          issue;
    logic          scan_hit;
    logic          cnt_at_end;

    logic          vwe;
    logic [VW-1:0] vwaddr;
    vstate_t       vwdata;
    vstate_t       vrdata;
    alu_op_t       alu_op;
    weight_t       alu_sum;
    logic          alu_lt;

    assign cnt_idx    = cnt_reg[VW-1:0];
    assign src_wide   = {4'b0, src_reg};
    assign src_idx    = src_wide[VW-1:0];
    assign src_ext    = {3'b0, src_reg};
    assign pick_wide  = 8'(pick_reg);
    assign pick_vtx   = pick_wide[3:0];
    assign cnt_wide   = 8'(cnt_idx);
    assign cnt_vtx    = cnt_wide[3:0];
    assign cnt_at_end = (cnt_reg == CNT_END);
    assign issue      = ((state_reg == ST_SCAN) || (state_reg == ST_RELAX)) && !cnt_at_end;
    assign scan_hit   = (state_reg == ST_SCAN) && rdv_reg && !vrdata.done && alu_lt;

    dspe_ram
    #(
        .ADDR_BITS (VW),
        .DATA_BITS ($bits(vstate_t))
    )
    u_vmem
    (
        .clk   (clk),
        .we    (vwe),
        .waddr (vwaddr),
        .wdata (vwdata),
        .raddr (cnt_idx),
        .rdata (vrdata)
    );

    dspe_alu u_alu
    (
        .op      (alu_op),
        .cur     (vrdata.path_len),
        .base    (least_reg),
        .weight  (mrdata),
        .no_edge (no_edge),
        .sum     (alu_sum),
        .lt      (alu_lt)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (run.start)
                begin
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                if (src_ext < N_EXT)
                begin
                    state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (cnt_at_end)
                begin
                    state_next = (found_reg || scan_hit) ? ST_RELAX : ST_OUT_READ;
                end
            end
            ST_RELAX:
            begin
                if (cnt_at_end)
                begin
                    state_next = (iter_reg == ITER_LAST) ? ST_OUT_READ : ST_SCAN;
                end
            end
            ST_OUT_READ:
            begin
                state_next = ST_OUT_LOAD;
            end
            ST_OUT_LOAD:
            begin
                if (out_free)
                begin
                    state_next = (cnt_reg == CNT_LAST) ? ST_IDLE : ST_OUT_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Counters and datapath registers
    always_comb
    begin
        cnt_next   = cnt_reg;
        iter_next  = iter_reg;
        found_next = found_reg;
        least_next = least_reg;
        pick_next  = pick_reg;
        src_next   = src_reg;
        idx_next   = cnt_idx;
        rdv_next   = issue;
        case (state_reg)
            ST_IDLE:
            begin
                if (run.start)
                begin
                    src_next = run.source;
                    cnt_next = '0;
                end
            end
            ST_REDUCE:
            begin
                if (src_ext >= N_EXT)
                begin
                    src_next = 4'(src_ext - N_EXT);
                end
            end
            ST_INIT:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    cnt_next   = '0;
                    iter_next  = '0;
                    found_next = 1'b0;
                    least_next = no_edge;
                end
            end
            ST_SCAN:
            begin
                if (scan_hit)
                begin
                    least_next = vrdata.path_len;
                    pick_next  = idx_reg;
                    found_next = 1'b1;
                end
                cnt_next = cnt_at_end ? '0 : cnt_reg + 1'b1;
            end
            ST_RELAX:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_at_end)
                begin
                    cnt_next   = '0;
                    iter_next  = iter_reg + 1'b1;
                    found_next = 1'b0;
                    least_next = no_edge;
                end
            end
            ST_OUT_LOAD:
            begin
                if (out_free)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    // Memory, unit and result controls
    always_comb
    begin
        vwe         = 1'b0;
        vwaddr      = idx_reg;
        vwdata      = vrdata;
        alu_op      = ALU_SCAN;
        maddr       = {pick_reg, cnt_idx};
        idle        = 1'b0;
        out_req     = '0;
        case (state_reg)
            ST_IDLE:
            begin
                idle = 1'b1;
            end
            ST_INIT:
            begin
                vwe             = 1'b1;
                vwaddr          = cnt_idx;
                vwdata.done     = 1'b0;
                vwdata.prev     = src_reg;
                vwdata.path_len = (cnt_idx == src_idx) ? '0 : no_edge;
            end
            ST_RELAX:
            begin
                alu_op          = ALU_RELAX;
                vwe             = rdv_reg;
                vwdata.done     = vrdata.done || (idx_reg == pick_reg);
                vwdata.prev     = alu_lt ? pick_vtx : vrdata.prev;
                vwdata.path_len = alu_lt ? alu_sum : vrdata.path_len;
            end
            ST_OUT_LOAD:
            begin
                alu_op              = ALU_REACH;
                out_req.load        = out_free;
                out_req.vertex      = cnt_vtx;
                out_req.path_length = vrdata.path_len;
                out_req.reachable   = alu_lt;
                out_req.predecessor = vrdata.prev;
                out_req.last        = (cnt_reg == CNT_LAST);
            end
            default:
            begin
                vwe = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            iter_reg  <= '0;
            found_reg <= 1'b0;
            rdv_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            iter_reg  <= iter_next;
            found_reg <= found_next;
            rdv_reg   <= rdv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        least_reg <= least_next;
        pick_reg  <= pick_next;
        src_reg   <= src_next;
    end

endmodule

// ===== rtl/dense_shortest_path_engine_top.sv =====
// Top level of the dense shortest-path engine: stream ports, config register,
// weight matrix RAM, result register. Depends on dspe_pkg, dspe_ram, dspe_seq.
`timescale 1ns / 1ps

//  Channel   Signals                            Moves
//  -------   --------------------------------   ---------------------------------------
//  s_axis    tvalid tready tdata[31:0] tuser    one request: weight write or run start
//  m_axis    tvalid tready tdata[31:0] tlast    one result per vertex, ascending order
//  cfg       cfg_valid cfg_ready cfg_data[19:0] no_edge_value register write
//
//  A weight write request produces no result and leaves the input ready for the next request.
//  A run request folds the source vertex into range, seeds the vertex state, then per
//  selected vertex runs a min-scan and a relax sweep over all vertices, all through the
//  one add/compare unit and the simple dual-port vertex-state RAM, then reads out one
//  result per vertex. The sweeps end early when no reachable unvisited vertex is left.
//  Results leave through a one-deep register; a stalled m_axis_tready holds the sweep.
//  Reset clears control state and sets no_edge_value to 999999; the matrix stays undefined.

module dense_shortest_path_engine_top
#(
    parameter int NUM_VERTICES = dspe_pkg::DSPE_VERTICES
)
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // [3:0] from_vertex, [7:4] to_vertex, [27:8] edge_weight, [31:28] source_vertex
    input  logic [31:0]       s_axis_tdata,
    // [0] func
    input  logic              s_axis_tuser,

    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // [3:0] vertex, [23:4] path_length, [24] reachable, [28:25] predecessor, [31:29] zero
    output logic [31:0]       m_axis_tdata,
    output logic              m_axis_tlast,

    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  dspe_pkg::weight_t cfg_data
);

    import dspe_pkg::*;

    localparam int VW = $clog2(NUM_VERTICES);
    localparam logic [6:0] N_EXT = 7'(NUM_VERTICES);

    weight_t       no_edge_reg;
    logic          m_valid_reg;
    logic [31:0]   m_data_reg;
    logic          m_last_reg;

    func_t         func;
    vtx_t          from_vertex;
    vtx_t          to_vertex;
    weight_t       edge_weight;
    vtx_t          source_vertex;
    logic [7:0]    from_wide;
    logic [7:0]    to_wide;
    logic          accept;
    logic          wr_en;
    logic [2*VW-1:0] wr_addr;
    logic [2*VW-1:0] rd_addr;
    weight_t       rd_weight;

    logic          seq_idle;
    logic          out_free;
    run_req_t      run;
    out_req_t      out_req;

    // Unpack the request
    assign func          = func_t'(s_axis_tuser);
    assign from_vertex   = s_axis_tdata[3:0];
    assign to_vertex     = s_axis_tdata[7:4];
    assign edge_weight   = s_axis_tdata[27:8];
    assign source_vertex = s_axis_tdata[31:28];
    assign from_wide     = {4'b0, from_vertex};
    assign to_wide       = {4'b0, to_vertex};

    // Accept requests only while the sequencer sits idle
    assign s_axis_tready = seq_idle;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Drop weight writes that point outside the matrix
    assign wr_en   = accept && (func == FUNC_WRITE) &&
                     (from_wide[6:0] < N_EXT) && (to_wide[6:0] < N_EXT);
    assign wr_addr = {from_wide[VW-1:0], to_wide[VW-1:0]};

    assign run.start  = accept && (func == FUNC_RUN);
    assign run.source = source_vertex;

    // Configuration is always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            no_edge_reg <= DSPE_NO_EDGE_RESET;
        end
        else if (cfg_valid)
        begin
            no_edge_reg <= cfg_data;
        end
    end

    dspe_ram
    #(
        .ADDR_BITS (2 * VW),
        .DATA_BITS (DSPE_WEIGHT_BITS)
    )
    u_wmem
    (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (edge_weight),
        .raddr (rd_addr),
        .rdata (rd_weight)
    );

    dspe_seq
    #(
        .NUM_VERTICES (NUM_VERTICES)
    )
    u_seq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .no_edge  (no_edge_reg),
        .run      (run),
        .out_free (out_free),
        .idle     (seq_idle),
        .out_req  (out_req),
        .maddr    (rd_addr),
        .mrdata   (rd_weight)
    );

    // Result register: free when empty or being taken this cycle
    assign out_free = !m_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (out_req.load)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_req.load)
        begin
            m_data_reg <= {3'b0, out_req.predecessor, out_req.reachable,
                           out_req.path_length, out_req.vertex};
            m_last_reg <= out_req.last;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;

endmodule

// ===== rtl/dspe_checker.sv =====
// Port-level checks of the shortest-path engine, bound to the top level.
// Depends on dspe_pkg for the request kind codes.
`timescale 1ns / 1ps

module dspe_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    import dspe_pkg::*;

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // A run request makes the block busy right away
    a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == FUNC_RUN) |=> !s_axis_tready)
        else $error("ready after run request");

    // A weight write leaves the block ready for the next request
    a_write_quick: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == FUNC_WRITE) |=> s_axis_tready)
        else $error("not ready after weight write");

    // No new request while a result sweep is still under way
    a_sweep_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("ready during result sweep");

    // Nothing follows the final result of a run
    a_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid)
        else $error("result after final vertex");

endmodule

bind dense_shortest_path_engine_top dspe_checker u_chk
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
